### hdl/salc_pkg.sv
package salc_pkg;

	localparam int SETS_DEF = 64;
	localparam int WAYS_DEF = 8;
	localparam int ADDR_BITS_DEF = 32;

	localparam int TAG_W = 32;
	localparam int AGE_W = 3;
	localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam int IDX_RAW_W = 7;

	localparam logic [3:0] WAYS_RST = 4'd1;
	localparam logic [3:0] OFFSET_RST = 4'd4;
	localparam logic [2:0] SETB_RST = 3'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAYS = 2'd0,
		CFG_OFFSET = 2'd1,
		CFG_SETB = 2'd2,
		CFG_PREFETCH = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic mode;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [1:0] memory_reads;
		logic memory_write;
		logic [CNT_W-1:0] total_reads;
		logic [CNT_W-1:0] total_writes;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic rd;
		logic upd;
		logic pf;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic miss;
		logic pf_en;
	} status_t;

endpackage

### hdl/salc_ctrl.sv
module salc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input salc_pkg::status_t status,
	output salc_pkg::cmd_t cmd,
	output logic busy
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DRD = 6'b000010,
		S_DUPD = 6'b000100,
		S_PRD = 6'b001000,
		S_PUPD = 6'b010000,
		S_FIN = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = S_DRD;
				end
			end
			S_DRD: begin
				cmd.rd = 1'b1;
				state_d = S_DUPD;
			end
			S_DUPD: begin
				cmd.upd = 1'b1;
				state_d = (status.miss && status.pf_en) ? S_PRD : S_FIN;
			end
			S_PRD: begin
				cmd.rd = 1'b1;
				cmd.pf = 1'b1;
				state_d = S_PUPD;
			end
			S_PUPD: begin
				cmd.upd = 1'b1;
				cmd.pf = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### hdl/salc_datapath.sv
module salc_datapath #(
	parameter int SETS = salc_pkg::SETS_DEF,
	parameter int WAYS = salc_pkg::WAYS_DEF,
	parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input salc_pkg::req_t request,
	input salc_pkg::cmd_t cmd,
	input logic cfg_we,
	input logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
	output salc_pkg::status_t status,
	output logic done,
	output salc_pkg::rsp_t result
);

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TW = salc_pkg::TAG_W;
	localparam int AW = salc_pkg::AGE_W;
	localparam int RAW_N = 1 << salc_pkg::IDX_RAW_W;
	localparam logic [63:0] AMASK = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);

	// raw set index modulo SETS, built at elaboration
	logic [SET_W-1:0] mod_tbl [RAW_N];
	for (genvar g = 0; g < RAW_N; g++) begin : g_mod
		assign mod_tbl[g] = SET_W'(g % SETS);
	end

	logic [3:0] ways_q, offset_q;
	logic [2:0] setb_q;
	logic pf_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= salc_pkg::WAYS_RST;
			offset_q <= salc_pkg::OFFSET_RST;
			setb_q <= salc_pkg::SETB_RST;
			pf_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				salc_pkg::CFG_WAYS: ways_q <= cfg_data;
				salc_pkg::CFG_OFFSET: offset_q <= cfg_data;
				salc_pkg::CFG_SETB: setb_q <= cfg_data[2:0];
				salc_pkg::CFG_PREFETCH: pf_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// address split
	localparam int IDX_RAW_W_L = salc_pkg::IDX_RAW_W;
	logic [63:0] daddr, paddr;
	logic [IDX_RAW_W_L-1:0] draw, praw;
	logic [IDX_RAW_W_L-1:0] smask;
	logic [4:0] tshift;
	logic [TW-1:0] dtag, ptag;

	always_comb begin
		daddr = {32'd0, request.address} & AMASK;
		paddr = (daddr + (64'd1 << offset_q)) & AMASK;
		smask = IDX_RAW_W_L'((8'd1 << setb_q) - 8'd1);
		draw = IDX_RAW_W_L'(daddr >> offset_q) & smask;
		praw = IDX_RAW_W_L'(paddr >> offset_q) & smask;
		tshift = 5'(offset_q) + 5'(setb_q);
		dtag = TW'(daddr >> tshift);
		ptag = TW'(paddr >> tshift);
	end

	logic [SET_W-1:0] dset_q, pset_q;
	logic [TW-1:0] dtag_q, ptag_q;
	logic mode_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			dset_q <= mod_tbl[draw];
			pset_q <= mod_tbl[praw];
			dtag_q <= dtag;
			ptag_q <= ptag;
			mode_q <= request.mode;
		end
	end

	// set memory, one row per set
	logic [WAYS-1:0][TW-1:0] tag_mem [SETS];
	logic [WAYS-1:0][AW-1:0] age_mem [SETS];
	logic [WAYS-1:0] vld_mem [SETS];
	logic [SETS-1:0] row_vld_q;

	logic [WAYS-1:0][TW-1:0] tag_rd_q, tag_new;
	logic [WAYS-1:0][AW-1:0] age_rd_q, age_new, age_cur;
	logic [WAYS-1:0] vld_rd_q, vld_new, vld_cur;
	logic row_rd_q;

	logic [SET_W-1:0] cur_set;
	logic [TW-1:0] cur_tag;
	assign cur_set = cmd.pf ? pset_q : dset_q;
	assign cur_tag = cmd.pf ? ptag_q : dtag_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			tag_rd_q <= tag_mem[cur_set];
			age_rd_q <= age_mem[cur_set];
			vld_rd_q <= vld_mem[cur_set];
		end
		if (cmd.upd) begin
			tag_mem[cur_set] <= tag_new;
			age_mem[cur_set] <= age_new;
			vld_mem[cur_set] <= vld_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			row_rd_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				row_rd_q <= row_vld_q[cur_set];
			end
			if (cmd.upd) begin
				row_vld_q[cur_set] <= 1'b1;
			end
		end
	end

	assign vld_cur = row_rd_q ? vld_rd_q : '0;
	assign age_cur = row_rd_q ? age_rd_q : '0;

	// lookup and recency update
	logic [3:0] n_eff;
	logic found, miss;
	logic [WI-1:0] fidx, vidx, tgt;
	logic [AW-1:0] a_tgt;

	always_comb begin
		if (ways_q == 4'd0) begin
			n_eff = 4'd1;
		end else if (int'(ways_q) > WAYS) begin
			n_eff = 4'(WAYS);
		end else begin
			n_eff = ways_q;
		end

		found = 1'b0;
		fidx = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && (i < int'(n_eff)) &&
			    (!vld_cur[i] || tag_rd_q[i] == cur_tag)) begin
				found = 1'b1;
				fidx = WI'(i);
			end
		end

		vidx = '0;
		for (int i = 1; i < WAYS; i++) begin
			if ((i < int'(n_eff)) && (age_cur[i] > age_cur[vidx])) begin
				vidx = WI'(i);
			end
		end

		tgt = found ? fidx : vidx;
		a_tgt = age_cur[tgt];
		tag_new = tag_rd_q;
		age_new = age_cur;
		vld_new = vld_cur;
		miss = 1'b1;

		if (found && !vld_cur[fidx]) begin
			for (int j = 0; j < WAYS; j++) begin
				if (vld_cur[j] && age_cur[j] < salc_pkg::AGE_MAX) begin
					age_new[j] = age_cur[j] + AW'(1);
				end
			end
			vld_new[tgt] = 1'b1;
			tag_new[tgt] = cur_tag;
			age_new[tgt] = '0;
		end else begin
			if (found) begin
				miss = 1'b0;
			end
			if (!(found && cmd.pf)) begin
				for (int j = 0; j < WAYS; j++) begin
					if (vld_cur[j] && age_cur[j] < a_tgt &&
					    age_cur[j] < salc_pkg::AGE_MAX) begin
						age_new[j] = age_cur[j] + AW'(1);
					end
				end
				age_new[tgt] = '0;
			end
			if (!found) begin
				tag_new[tgt] = cur_tag;
			end
		end
	end

	assign status.miss = miss;
	assign status.pf_en = pf_en_q;

	// totals and result
	logic dmiss_q, pmiss_q;
	logic [salc_pkg::CNT_W-1:0] rd_tot_q, wr_tot_q, hit_tot_q, miss_tot_q;
	logic [1:0] reads;
	logic [salc_pkg::CNT_W:0] rd_sum;
	logic [salc_pkg::CNT_W-1:0] rd_next, wr_next, hit_next, miss_next;
	logic done_q;
	salc_pkg::rsp_t result_q;

	always_comb begin
		reads = {1'b0, dmiss_q} + {1'b0, pmiss_q};
		rd_sum = {1'b0, rd_tot_q} + (salc_pkg::CNT_W + 1)'(reads);
		rd_next = rd_sum[salc_pkg::CNT_W] ? '1 : rd_sum[salc_pkg::CNT_W-1:0];
		wr_next = (mode_q && wr_tot_q != '1) ? wr_tot_q + 1'b1 : wr_tot_q;
		hit_next = (!dmiss_q && hit_tot_q != '1) ? hit_tot_q + 1'b1 : hit_tot_q;
		miss_next = (dmiss_q && miss_tot_q != '1) ? miss_tot_q + 1'b1 : miss_tot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmiss_q <= 1'b0;
			pmiss_q <= 1'b0;
			rd_tot_q <= '0;
			wr_tot_q <= '0;
			hit_tot_q <= '0;
			miss_tot_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.latch) begin
				pmiss_q <= 1'b0;
			end
			if (cmd.upd && !cmd.pf) begin
				dmiss_q <= miss;
			end
			if (cmd.upd && cmd.pf) begin
				pmiss_q <= miss;
			end
			if (cmd.finish) begin
				rd_tot_q <= rd_next;
				wr_tot_q <= wr_next;
				hit_tot_q <= hit_next;
				miss_tot_q <= miss_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.hit <= !dmiss_q;
			result_q.memory_reads <= reads;
			result_q.memory_write <= mode_q;
			result_q.total_reads <= rd_next;
			result_q.total_writes <= wr_next;
			result_q.total_hits <= hit_next;
			result_q.total_misses <= miss_next;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

### hdl/set_assoc_lru_cache_prefetch_core.sv
// channel   | signals                          | transfer
// ----------+----------------------------------+-----------------------------
// request   | start, busy, request             | edge with start && !busy
// result    | done, result                     | edge ending the done cycle
// config    | cfg_we, cfg_index, cfg_data      | edge with cfg_we high
//
// An access steps through states DRD, DUPD and FIN; a demand miss with prefetch
// enabled adds PRD and PUPD before FIN. busy is high in these states and done is
// registered from FIN. The single port of the set memory sets this: each lookup
// is a registered row read followed by a row write-back.
// arst_n clears the FSM, the per-set row valid bits and totals, and resets config.
// The result receiver cannot stall; done is high for one cycle per access.
module set_assoc_lru_cache_prefetch_core #(
	parameter int SETS = salc_pkg::SETS_DEF,
	parameter int WAYS = salc_pkg::WAYS_DEF,
	parameter int ADDR_BITS = salc_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input salc_pkg::req_t request,
	output logic done,
	output salc_pkg::rsp_t result,
	input logic cfg_we,
	input logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [salc_pkg::CFG_DATA_W-1:0] cfg_data
);

	salc_pkg::cmd_t cmd;
	salc_pkg::status_t status;

	salc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.status(status),
		.cmd(cmd),
		.busy(busy)
	);

	salc_datapath #(
		.SETS(SETS),
		.WAYS(WAYS),
		.ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.status(status),
		.done(done),
		.result(result)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted access did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	a_hit_no_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.memory_reads == 2'd0)
		else $error("hit caused memory reads");

	a_miss_reads: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.memory_reads != 2'd0)
		else $error("miss without a fill read");

endmodule

### bench/set_assoc_lru_cache_prefetch_core_test.sv
`timescale 1ns / 1ps

module set_assoc_lru_cache_prefetch_core_test;

	localparam int NSETS = 64;
	localparam int NWAYS = 8;
	localparam int LIMIT = 400000;

	class cache_scoreboard;
		logic [31:0] tags [NSETS*NWAYS];
		bit valid [NSETS*NWAYS];
		logic [2:0] age [NSETS*NWAYS];
		logic [31:0] rd_cnt, wr_cnt, hit_cnt, miss_cnt;
		logic [3:0] ways_cfg, off_cfg;
		logic [2:0] setb_cfg;
		bit pf_cfg;
		salc_pkg::rsp_t pending [$];
		int errors;

		function void clear();
			for (int i = 0; i < NSETS*NWAYS; i++) begin
				tags[i] = '0;
				valid[i] = 0;
				age[i] = '0;
			end
			rd_cnt = 0;
			wr_cnt = 0;
			hit_cnt = 0;
			miss_cnt = 0;
			ways_cfg = salc_pkg::WAYS_RST;
			off_cfg = salc_pkg::OFFSET_RST;
			setb_cfg = salc_pkg::SETB_RST;
			pf_cfg = 0;
			errors = 0;
		endfunction

		function void write_reg(salc_pkg::cfg_idx_t idx, logic [3:0] val);
			case (idx)
				salc_pkg::CFG_WAYS: ways_cfg = val;
				salc_pkg::CFG_OFFSET: off_cfg = val;
				salc_pkg::CFG_SETB: setb_cfg = val[2:0];
				salc_pkg::CFG_PREFETCH: pf_cfg = val[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void promote(int base, int way);
			logic [2:0] a;
			a = age[base+way];
			for (int j = 0; j < NWAYS; j++)
				if (valid[base+j] && age[base+j] < a && age[base+j] < salc_pkg::AGE_MAX)
					age[base+j]++;
			age[base+way] = '0;
		endfunction

		// returns 1 when the block had to be filled
		function bit probe(logic [31:0] addr, bit is_pf);
			int base, n, victim, set_idx;
			logic [63:0] idx;
			logic [31:0] tg;
			idx = ({32'd0, addr} >> off_cfg) & ((64'd1 << setb_cfg) - 64'd1);
			set_idx = int'(idx % NSETS);
			tg = 32'(({32'd0, addr} >> (int'(off_cfg) + int'(setb_cfg))));
			base = set_idx * NWAYS;
			n = ways_cfg;
			if (n == 0) n = 1;
			if (n > NWAYS) n = NWAYS;
			for (int i = 0; i < n; i++) begin
				if (!valid[base+i]) begin
					for (int j = 0; j < NWAYS; j++)
						if (valid[base+j] && age[base+j] < salc_pkg::AGE_MAX)
							age[base+j]++;
					valid[base+i] = 1;
					tags[base+i] = tg;
					age[base+i] = '0;
					return 1;
				end
				if (tags[base+i] == tg) begin
					if (!is_pf) promote(base, i);
					return 0;
				end
			end
			victim = 0;
			for (int i = 1; i < n; i++)
				if (age[base+i] > age[base+victim]) victim = i;
			promote(base, victim);
			tags[base+victim] = tg;
			return 1;
		endfunction

		function void note_access(salc_pkg::req_t rq);
			salc_pkg::rsp_t r;
			r = '0;
			r.hit = !probe(rq.address, 0);
			if (r.hit) hit_cnt = bump(hit_cnt);
			else begin
				miss_cnt = bump(miss_cnt);
				r.memory_reads = 2'd1;
				rd_cnt = bump(rd_cnt);
				if (pf_cfg && probe(rq.address + (32'd1 << off_cfg), 1)) begin
					r.memory_reads = 2'd2;
					rd_cnt = bump(rd_cnt);
				end
			end
			if (rq.mode) wr_cnt = bump(wr_cnt);
			r.memory_write = rq.mode;
			r.total_reads = rd_cnt;
			r.total_writes = wr_cnt;
			r.total_hits = hit_cnt;
			r.total_misses = miss_cnt;
			pending.push_back(r);
		endfunction

		function void check_result(salc_pkg::rsp_t got);
			salc_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit) begin
				$error("hit exp %0d got %0d", e.hit, got.hit); errors++;
			end
			if (got.memory_reads !== e.memory_reads) begin
				$error("memory_reads exp %0d got %0d", e.memory_reads, got.memory_reads);
				errors++;
			end
			if (got.memory_write !== e.memory_write) begin
				$error("memory_write exp %0d got %0d", e.memory_write, got.memory_write);
				errors++;
			end
			if (got.total_reads !== e.total_reads) begin
				$error("total_reads exp %0d got %0d", e.total_reads, got.total_reads);
				errors++;
			end
			if (got.total_writes !== e.total_writes) begin
				$error("total_writes exp %0d got %0d", e.total_writes, got.total_writes);
				errors++;
			end
			if (got.total_hits !== e.total_hits) begin
				$error("total_hits exp %0d got %0d", e.total_hits, got.total_hits);
				errors++;
			end
			if (got.total_misses !== e.total_misses) begin
				$error("total_misses exp %0d got %0d", e.total_misses, got.total_misses);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	salc_pkg::req_t request = '0;
	salc_pkg::rsp_t result;
	logic cfg_we = 0;
	logic [salc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [salc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int cycles = 0;
	int gap_pct = 8;
	logic [31:0] hot_base;

	cache_scoreboard sb = new();

	set_assoc_lru_cache_prefetch_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_result(result);
		if (cycles > LIMIT) begin
			$display("set_assoc_lru_cache_prefetch_core_test: done, errors");
			$finish;
		end
	end

	task automatic set_reg(salc_pkg::cfg_idx_t idx, logic [3:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic apply(logic [3:0] w, logic [3:0] o, logic [2:0] s, bit p);
		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		set_reg(salc_pkg::CFG_WAYS, w);
		set_reg(salc_pkg::CFG_OFFSET, o);
		set_reg(salc_pkg::CFG_SETB, {1'b0, s});
		set_reg(salc_pkg::CFG_PREFETCH, {3'b0, p});
	endtask

	// one transfer: raise start at a falling edge, wait for the accepting edge
	task automatic access(bit m, logic [31:0] a);
		salc_pkg::req_t rq;
		if ($urandom_range(99) < gap_pct) begin
			start <= 0;
			request <= {1'($urandom_range(1)), $urandom()};
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		rq.mode = m;
		rq.address = a;
		start <= 1;
		request <= rq;
		do @(posedge clk); while (busy);
		sb.note_access(rq);
		@(negedge clk);
	endtask

	task automatic random_phase(int count);
		logic [31:0] a;
		for (int i = 0; i < count; i++) begin
			// mostly a small working set so hits, evictions and prefetch hits happen
			if ($urandom_range(9) < 8)
				a = hot_base + ($urandom_range(63) << $urandom_range(1, 6)) + $urandom_range(3);
			else
				a = $urandom();
			access(1'($urandom_range(1)), a);
		end
	endtask

	initial begin
		sb.clear();
		hot_base = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset config, extremes of address, both modes
		access(0, 32'h0);
		access(1, 32'h0);
		access(0, 32'hFFFF_FFFF);
		access(1, 32'h0000_000F);
		access(0, 32'h0000_0010);
		apply(4'd8, 4'd1, 3'd6, 1);
		access(0, 32'hFFFF_FFFF);          // prefetch wraps to the bottom
		access(1, 32'h0);                  // prefetched block hits
		for (int i = 0; i < 10; i++) access(i[0], i << 8); // fill and evict one set
		access(0, 32'h0);
		apply(4'd0, 4'd12, 3'd0, 1);       // ways 0 acts as 1
		access(0, 32'h0000_1000);
		access(0, 32'h0);
		access(1, 32'hAAAA_5555);
		apply(4'd15, 4'd15, 3'd7, 0);      // out of range values
		access(0, 32'h5555_AAAA);
		access(0, 32'hFFFF_0000);

		for (int ph = 0; ph < 12; ph++) begin
			apply(4'($urandom_range(15)), 4'($urandom_range(15)), 3'($urandom_range(7)),
			      1'($urandom_range(1)));
			if (ph % 4 == 0) apply(ph[3] ? 4'd8 : 4'd1, 4'd1, 3'd6, 1);
			gap_pct = (ph < 4) ? 8 : (ph < 8) ? 47 : 0;
			hot_base = $urandom() & 32'hFFF0_0000;
			random_phase(100);
		end

		start <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("set_assoc_lru_cache_prefetch_core_test: done, clean");
		else
			$display("set_assoc_lru_cache_prefetch_core_test: done, errors");
		$finish;
	end
endmodule

### files.f
hdl/salc_pkg.sv
hdl/salc_ctrl.sv
hdl/salc_datapath.sv
hdl/set_assoc_lru_cache_prefetch_core.sv
bench/set_assoc_lru_cache_prefetch_core_test.sv
